@@ rtl/core/bbe_pkg.sv @@
`timescale 1ns / 1ps

package bbe_pkg;

   // Input item kinds carried on req_tuser
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // Register indexes (byte address / 4)
   localparam logic [1:0] REG_THRESHOLD  = 2'd0;
   localparam logic [1:0] REG_FRAME_COLS = 2'd1;
   localparam logic [1:0] REG_FRAME_ROWS = 2'd2;

   localparam logic [7:0] THRESHOLD_RESET = 8'd127;
   localparam logic [8:0] FRAME_DIM_RESET = 9'd256;
   localparam int         FRAME_DIM_MIN   = 3;

   localparam logic [7:0] PIXEL_WHITE = 8'd255;
   localparam logic [7:0] PIXEL_BLACK = 8'd0;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [7:0] threshold;
      logic [8:0] frame_cols;
      logic [8:0] frame_rows;
      logic       restart;     // geometry written: start the frame again
   } bbe_cfg_type;

   // One classified pixel step, as handed from the front to the back
   typedef struct packed {
      logic       pix_bit;     // thresholded value, 1 is white
      logic       emit;        // this step releases a result
      logic       interior;    // result position lies off the frame border
      logic       done;        // result is the last of the frame
      logic [7:0] row;
      logic [7:0] col;
   } bbe_entry_type;

endpackage

@@ rtl/core/bbe_ram.sv @@
`timescale 1ns / 1ps

module bbe_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/bbe_front.sv @@
`timescale 1ns / 1ps

module bbe_front import bbe_pkg::*; #(
   parameter int MAX_COLS = 256,
   parameter int MAX_ROWS = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bbe_cfg_type                 cfg,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic                        req_opcode,
   input  logic [7:0]                  req_pixel,
   input  logic                        q_full,
   output logic                        q_push,
   output bbe_entry_type               q_entry,
   output logic [$clog2(MAX_COLS)-1:0] q_addr
);

   localparam int CAW = $clog2(MAX_COLS);
   localparam int CNW = $clog2(MAX_COLS + 1);
   localparam int IRW = $clog2(MAX_ROWS + 2);
   localparam int ERW = $clog2(MAX_ROWS);
   localparam int RNW = $clog2(MAX_ROWS + 1);

   logic [IRW-1:0] in_row_ff,   in_row_in;
   logic [CAW-1:0] in_col_ff,   in_col_in;
   logic [ERW-1:0] emit_row_ff, emit_row_in;
   logic [CAW-1:0] emit_col_ff, emit_col_in;

   logic [CNW-1:0] cols_val;
   logic [RNW-1:0] rows_val;
   logic           flushing;
   logic           ignore;
   logic           accept;
   logic           emit;
   logic           col_last;
   logic           ecol_last;
   logic           erow_last;
   logic           done;
   logic           interior;

   // Clamp the geometry to the supported range
   always_comb begin
      if (32'(cfg.frame_cols) < 32'(FRAME_DIM_MIN)) begin
         cols_val = CNW'(FRAME_DIM_MIN);
      end else if (32'(cfg.frame_cols) > 32'(MAX_COLS)) begin
         cols_val = CNW'(MAX_COLS);
      end else begin
         cols_val = CNW'(cfg.frame_cols);
      end
      if (32'(cfg.frame_rows) < 32'(FRAME_DIM_MIN)) begin
         rows_val = RNW'(FRAME_DIM_MIN);
      end else if (32'(cfg.frame_rows) > 32'(MAX_ROWS)) begin
         rows_val = RNW'(MAX_ROWS);
      end else begin
         rows_val = RNW'(cfg.frame_rows);
      end
   end

   // Once every pixel of the frame is in, any item pushes a black phantom pixel
   assign flushing  = 32'(in_row_ff) >= 32'(rows_val);
   assign ignore    = !flushing && (req_opcode == OP_DRAIN);
   assign req_tready = !q_full;
   assign accept    = req_tvalid && req_tready;
   assign q_push    = accept && !ignore;

   assign emit = (32'(in_row_ff) >= 32'd2) || ((in_row_ff == IRW'(1)) && (in_col_ff != '0));
   assign col_last  = (32'(in_col_ff) + 32'd1) >= 32'(cols_val);
   assign ecol_last = (32'(emit_col_ff) + 32'd1) >= 32'(cols_val);
   assign erow_last = (32'(emit_row_ff) + 32'd1) >= 32'(rows_val);
   assign done      = erow_last && ecol_last;
   assign interior  = (emit_row_ff != '0) && ((32'(emit_row_ff) + 32'd2) <= 32'(rows_val))
                   && (emit_col_ff != '0) && ((32'(emit_col_ff) + 32'd2) <= 32'(cols_val));

   always_comb begin
      q_entry.pix_bit  = !flushing && (req_pixel > cfg.threshold);
      q_entry.emit     = emit;
      q_entry.interior = interior;
      q_entry.done     = done;
      q_entry.row      = 8'(emit_row_ff);
      q_entry.col      = 8'(emit_col_ff);
      q_addr           = in_col_ff;
   end

   always_comb begin
      in_row_in   = in_row_ff;
      in_col_in   = in_col_ff;
      emit_row_in = emit_row_ff;
      emit_col_in = emit_col_ff;
      if (cfg.restart) begin
         in_row_in   = '0;
         in_col_in   = '0;
         emit_row_in = '0;
         emit_col_in = '0;
      end else if (q_push) begin
         if (col_last) begin
            in_col_in = '0;
            in_row_in = in_row_ff + IRW'(1);
         end else begin
            in_col_in = in_col_ff + CAW'(1);
         end
         if (emit) begin
            if (ecol_last) begin
               emit_col_in = '0;
               emit_row_in = emit_row_ff + ERW'(1);
            end else begin
               emit_col_in = emit_col_ff + CAW'(1);
            end
            if (done) begin
               in_row_in   = '0;
               in_col_in   = '0;
               emit_row_in = '0;
               emit_col_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff   <= '0;
         in_col_ff   <= '0;
         emit_row_ff <= '0;
         emit_col_ff <= '0;
      end else begin
         in_row_ff   <= in_row_in;
         in_col_ff   <= in_col_in;
         emit_row_ff <= emit_row_in;
         emit_col_ff <= emit_col_in;
      end
   end

endmodule

@@ rtl/core/bbe_queue.sv @@
`timescale 1ns / 1ps

module bbe_queue import bbe_pkg::*; #(
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bbe_entry_type     push_entry,
   input  logic [ADDR_W-1:0] push_addr,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output bbe_entry_type     head_entry,
   output logic [ADDR_W-1:0] head_addr
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int NW = $clog2(QUEUE_DEPTH + 1);

   bbe_entry_type     entry_ff [QUEUE_DEPTH];
   logic [ADDR_W-1:0] addr_ff  [QUEUE_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]     count_ff,  count_in;
   logic              do_push;
   logic              do_pop;

   assign full       = count_ff == NW'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = entry_ff[rd_ptr_ff];
   assign head_addr  = addr_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + NW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
         addr_ff[wr_ptr_ff]  <= push_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/core/bbe_back.sv @@
`timescale 1ns / 1ps

module bbe_back import bbe_pkg::*; #(
   parameter int MAX_COLS = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  bbe_entry_type               q_entry,
   input  logic [$clog2(MAX_COLS)-1:0] q_addr,
   output logic                        q_pop,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [7:0]                  rsp_pixel,
   output logic [7:0]                  rsp_row,
   output logic [7:0]                  rsp_col,
   output logic                        rsp_last
);

   localparam int CAW = $clog2(MAX_COLS);

   logic           s1_valid_ff, s1_valid_in;
   bbe_entry_type  s1_entry_ff;
   logic [CAW-1:0] s1_addr_ff;
   logic [8:0]     window_ff,   window_in;
   logic           out_valid_ff, out_valid_in;
   logic [7:0]     out_pixel_ff;
   logic [7:0]     out_row_ff;
   logic [7:0]     out_col_ff;
   logic           out_last_ff;

   logic [1:0]     line_rd;     // [1] middle line, [0] upper line
   logic [1:0]     line_wr;
   logic           advance;
   logic           load_out;
   logic           white;

   // Non-emitting steps never wait on the output register
   assign advance  = s1_valid_ff && (!s1_entry_ff.emit || !out_valid_ff || rsp_tready);
   assign q_pop    = q_valid && (!s1_valid_ff || advance);
   assign load_out = advance && s1_entry_ff.emit;

   // Shift the lines down one row at this column
   assign line_wr = {s1_entry_ff.pix_bit, line_rd[1]};

   bbe_ram #(
      .WIDTH(2),
      .DEPTH(MAX_COLS)
   ) u_line_ram (
      .clock  (clock),
      .wr_en  (advance),
      .wr_addr(s1_addr_ff),
      .wr_data(line_wr),
      .rd_en  (q_pop),
      .rd_addr(q_addr),
      .rd_data(line_rd)
   );

   // Newest column enters at the top bits, row 0 lowest
   always_comb begin
      window_in = window_ff;
      if (advance) begin
         window_in = {s1_entry_ff.pix_bit, line_rd[1], line_rd[0], window_ff[8:3]};
      end
      white = window_in[4] || (s1_entry_ff.interior && (window_in == '0));
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (q_pop) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_entry_ff <= q_entry;
         s1_addr_ff  <= q_addr;
      end
      if (load_out) begin
         out_pixel_ff <= white ? PIXEL_WHITE : PIXEL_BLACK;
         out_row_ff   <= s1_entry_ff.row;
         out_col_ff   <= s1_entry_ff.col;
         out_last_ff  <= s1_entry_ff.done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         window_ff    <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         window_ff    <= window_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_pixel  = out_pixel_ff;
   assign rsp_row    = out_row_ff;
   assign rsp_col    = out_col_ff;
   assign rsp_last   = out_last_ff;

endmodule

@@ rtl/core/binary_boundary_extract_3x3.sv @@
`timescale 1ns / 1ps
// A pixel's result passes the queue, the s1 register and the output register before rsp_tvalid.
// Throughput: one transaction per cycle unless rsp_tready stalls fill the queue, set by the single
// write and single registered read port of the two-row line buffer RAM.
// Reset (synchronous, active high) clears counters, window and valid flags and
// loads the registers with their defaults; line buffer contents are not cleared.

module binary_boundary_extract_3x3 import bbe_pkg::*; #(
   parameter int MAX_COLS = 256,
   parameter int MAX_ROWS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // [7:0] pixel_in
   input  logic        req_tuser,     // [0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,     // [7:0] pixel_out, [15:8] out_row, [23:16] out_col
   output logic        rsp_tlast,     // frame_done
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CAW = $clog2(MAX_COLS);

   logic [7:0]     threshold_ff,  threshold_in;
   logic [8:0]     frame_cols_ff, frame_cols_in;
   logic [8:0]     frame_rows_ff, frame_rows_in;
   logic           wr_en;
   logic [1:0]     reg_index;
   logic           restart;
   bbe_cfg_type    cfg;

   logic           q_push;
   logic           q_full;
   bbe_entry_type  q_push_entry;
   logic [CAW-1:0] q_push_addr;
   logic           q_pop;
   logic           q_valid;
   bbe_entry_type  q_head_entry;
   logic [CAW-1:0] q_head_addr;

   logic [7:0]     rsp_pixel;
   logic [7:0]     rsp_row;
   logic [7:0]     rsp_col;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = csr_paddr[3:2];

   always_comb begin
      threshold_in  = threshold_ff;
      frame_cols_in = frame_cols_ff;
      frame_rows_in = frame_rows_ff;
      restart       = 1'b0;
      if (wr_en) begin
         unique case (reg_index)
            REG_THRESHOLD:  threshold_in = csr_pwdata[7:0];
            REG_FRAME_COLS: begin
               frame_cols_in = csr_pwdata[8:0];
               restart       = 1'b1;
            end
            REG_FRAME_ROWS: begin
               frame_rows_in = csr_pwdata[8:0];
               restart       = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_THRESHOLD:  csr_prdata = 32'(threshold_ff);
         REG_FRAME_COLS: csr_prdata = 32'(frame_cols_ff);
         REG_FRAME_ROWS: csr_prdata = 32'(frame_rows_ff);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= THRESHOLD_RESET;
         frame_cols_ff <= FRAME_DIM_RESET;
         frame_rows_ff <= FRAME_DIM_RESET;
      end else begin
         threshold_ff  <= threshold_in;
         frame_cols_ff <= frame_cols_in;
         frame_rows_ff <= frame_rows_in;
      end
   end

   always_comb begin
      cfg.threshold  = threshold_ff;
      cfg.frame_cols = frame_cols_ff;
      cfg.frame_rows = frame_rows_ff;
      cfg.restart    = restart;
   end

   bbe_front #(
      .MAX_COLS(MAX_COLS),
      .MAX_ROWS(MAX_ROWS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_opcode(req_tuser),
      .req_pixel (req_tdata),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_push_entry),
      .q_addr    (q_push_addr)
   );

   bbe_queue #(
      .ADDR_W(CAW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_entry(q_push_entry),
      .push_addr (q_push_addr),
      .full      (q_full),
      .pop       (q_pop),
      .head_valid(q_valid),
      .head_entry(q_head_entry),
      .head_addr (q_head_addr)
   );

   bbe_back #(
      .MAX_COLS(MAX_COLS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_entry   (q_head_entry),
      .q_addr    (q_head_addr),
      .q_pop     (q_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_pixel (rsp_pixel),
      .rsp_row   (rsp_row),
      .rsp_col   (rsp_col),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = {rsp_col, rsp_row, rsp_pixel};

endmodule

@@ rtl/core/bbe_checker.sv @@
`timescale 1ns / 1ps

module bbe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast
);

   // Pipeline and queue come out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> (!rsp_tvalid && req_tready))
      else $error("result pending or input blocked after reset");

   // A result is only ever pure black or pure white
   a_binary_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:0] == 8'd0 || rsp_tdata[7:0] == 8'd255))
      else $error("result pixel neither black nor white");

   // Frame end never falls on the first row or column: frames are at least 3x3
   a_last_col: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata[23:16] != 8'd0 && rsp_tdata[15:8] != 8'd0))
      else $error("frame end reported at first row or column");

   // Hold a stalled transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled result changed");

endmodule

bind binary_boundary_extract_3x3 bbe_checker u_bbe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tlast (rsp_tlast)
);

@@ tb/bbe_checker.sv @@
`timescale 1ns / 1ps

module bbe_tb_checker import bbe_pkg::*; #(
   parameter int MAX_COLS = 256,
   parameter int MAX_ROWS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,     // [7:0] pixel_in
   input  logic        req_tuser,     // [0] opcode
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,     // [7:0] pixel_out, [15:8] out_row, [23:16] out_col
   input  logic        rsp_tlast,     // frame_done
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          error_count,
   output int          pending_count,
   output int          result_count,
   output int          interior_count
);

   typedef struct packed {
      logic [7:0] pixel;
      logic [7:0] row;
      logic [7:0] col;
      logic       done;
   } boundary_pixel_type;

   boundary_pixel_type expected_pixels[$];

   logic [7:0]  threshold;
   logic [8:0]  cols_raw;
   logic [8:0]  rows_raw;
   bit          line_upper[MAX_COLS];
   bit          line_middle[MAX_COLS];
   logic [8:0]  window;
   int unsigned in_row, in_col, out_row, out_col;
   int          errors = 0;
   int          results = 0;
   int          interiors = 0;

   function automatic int unsigned clamp_dim(input logic [8:0] raw, input int unsigned limit);
      if (raw < FRAME_DIM_MIN) return FRAME_DIM_MIN;
      if (raw > limit) return limit;
      return 32'(raw);
   endfunction

   task automatic restart_frame();
      window  = '0;
      in_row  = 0;
      in_col  = 0;
      out_row = 0;
      out_col = 0;
   endtask

   // Advance the line buffers and window by one transaction, queue the pixel it releases
   task automatic predict_boundary(input logic op, input logic [7:0] pix);
      int unsigned        cols, rows, idx;
      bit                 px_bit, up_old, mid_old, releases, interior;
      boundary_pixel_type px;
      cols = clamp_dim(cols_raw, MAX_COLS);
      rows = clamp_dim(rows_raw, MAX_ROWS);
      if (in_row >= rows)
         px_bit = 1'b0;               // flushing: feed a black phantom row
      else if (op == OP_PIXEL)
         px_bit = (pix > threshold);
      else
         return;                      // drain inside the frame: drop it
      idx = (in_col >= MAX_COLS) ? MAX_COLS - 1 : in_col;
      up_old  = line_upper[idx];
      mid_old = line_middle[idx];
      line_upper[idx]  = mid_old;
      line_middle[idx] = px_bit;
      window = {px_bit, mid_old, up_old, window[8:3]};
      releases = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      if (in_col + 1 >= cols) begin
         in_col = 0;
         in_row++;
      end else begin
         in_col++;
      end
      if (!releases) return;
      interior = out_row >= 1 && out_row + 2 <= rows && out_col >= 1 && out_col + 2 <= cols
                 && window == '0;
      px.pixel = (window[4] || interior) ? PIXEL_WHITE : PIXEL_BLACK;
      px.row   = out_row[7:0];
      px.col   = out_col[7:0];
      px.done  = (out_row + 1 >= rows) && (out_col + 1 >= cols);
      if (interior) interiors++;
      if (out_col + 1 >= cols) begin
         out_col = 0;
         out_row++;
      end else begin
         out_col++;
      end
      if (px.done) restart_frame();
      expected_pixels.push_back(px);
   endtask

   task automatic compare_field(input string field_name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field_name, want, got);
      end
   endtask

   task automatic check_boundary(input logic [23:0] data, input logic last);
      boundary_pixel_type px;
      results++;
      if (expected_pixels.size() == 0) begin
         errors++;
         $display("%0t: unexpected result: expected none, actual pixel %0d row %0d col %0d last %0b",
                  $time, data[7:0], data[15:8], data[23:16], last);
         return;
      end
      px = expected_pixels.pop_front();
      compare_field("pixel_out", px.pixel, data[7:0]);
      compare_field("out_row", px.row, data[15:8]);
      compare_field("out_col", px.col, data[23:16]);
      compare_field("frame_done", {7'd0, px.done}, {7'd0, last});
   endtask

   always @(posedge clock) begin
      if (reset) begin
         threshold = THRESHOLD_RESET;
         cols_raw  = FRAME_DIM_RESET;
         rows_raw  = FRAME_DIM_RESET;
         foreach (line_upper[i]) line_upper[i] = 1'b0;
         foreach (line_middle[i]) line_middle[i] = 1'b0;
         restart_frame();
         expected_pixels.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_THRESHOLD: threshold = csr_pwdata[7:0];
               REG_FRAME_COLS: begin
                  cols_raw = csr_pwdata[8:0];
                  restart_frame();
               end
               REG_FRAME_ROWS: begin
                  rows_raw = csr_pwdata[8:0];
                  restart_frame();
               end
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) predict_boundary(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) check_boundary(rsp_tdata, rsp_tlast);
      end
      error_count    <= errors;
      pending_count  <= expected_pixels.size();
      result_count   <= results;
      interior_count <= interiors;
   end

endmodule

@@ tb/binary_boundary_extract_3x3_tb.sv @@
`timescale 1ns / 1ps

module binary_boundary_extract_3x3_tb;
   import bbe_pkg::*;

   localparam int MAX_DIM       = 256;
   localparam int ITEM_TARGET   = 125;
   localparam int IDLE_PCT      = 28;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 10;

   localparam int MODE_WHOLE   = 0;
   localparam int MODE_ABANDON = 1;
   localparam int MODE_RETUNE  = 2;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tuser = OP_PIXEL;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int error_count, pending_count, result_count, interior_count;

   bit         calm = 1'b0;
   int         idle_cycles = 0;
   int         counted_items = 0;
   int         frames_sent = 0;
   logic [7:0] cur_thr = THRESHOLD_RESET;
   int         cur_cols = MAX_DIM;
   int         cur_rows = MAX_DIM;

   always #5 clock = ~clock;

   binary_boundary_extract_3x3 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   bbe_tb_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_pready    (csr_pready),
      .error_count   (error_count),
      .pending_count (pending_count),
      .result_count  (result_count),
      .interior_count(interior_count)
   );

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // Watchdog: any transaction on any port resets the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int eff_dim(input logic [8:0] raw);
      if (raw < FRAME_DIM_MIN) return FRAME_DIM_MIN;
      if (raw > MAX_DIM) return MAX_DIM;
      return 32'(raw);
   endfunction

   function automatic logic [7:0] pick_pixel(input int black_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 5) return cur_thr;
      if (roll < 10) return cur_thr + 8'd1;
      if (roll < 20) return 8'($urandom);
      if ($urandom_range(0, 99) < black_pct) return 8'($urandom_range(0, cur_thr));
      if (cur_thr == 8'd255) return 8'd255;
      return 8'($urandom_range(cur_thr + 1, 255));
   endfunction

   task automatic send_item(input logic op, input logic [7:0] pix);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= pix;
      do @(posedge clock); while (!req_tready);
   endtask

   // Hold off until every expected pixel is out, then let the pipeline settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [7:0] thr, input logic [8:0] cols_raw,
                            input logic [8:0] rows_raw);
      logic [31:0] junk;
      wait_idle();
      // unused upper bits now and then carry noise
      junk = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
      csr_write(REG_THRESHOLD, {junk[31:8], thr});
      csr_write(REG_FRAME_COLS, {junk[31:9], cols_raw});
      csr_write(REG_FRAME_ROWS, {junk[31:9], rows_raw});
      cur_thr  = thr;
      cur_cols = eff_dim(cols_raw);
      cur_rows = eff_dim(rows_raw);
   endtask

   task automatic run_frame(input int black_pct, input int mode);
      int total, cut_at;
      total  = cur_cols * cur_rows;
      cut_at = (mode == MODE_WHOLE) ? total : $urandom_range(0, total - 1);
      for (int i = 0; i < total; i++) begin
         if (i == cut_at) begin
            if (mode == MODE_ABANDON) return;
            wait_idle();
            cur_thr = 8'($urandom);
            csr_write(REG_THRESHOLD, {24'd0, cur_thr});
         end
         // drains inside the frame are ignored by the block
         if ($urandom_range(0, 99) < 5) send_item(OP_DRAIN, 8'($urandom));
         send_item(OP_PIXEL, pick_pixel(black_pct));
         counted_items++;
      end
      // flush the pending row and one more pixel; pixels here count as drains
      for (int j = 0; j <= cur_cols; j++) begin
         send_item($urandom_range(0, 1) ? OP_DRAIN : OP_PIXEL, 8'($urandom));
         counted_items++;
      end
      frames_sent++;
   endtask

   initial begin
      logic [7:0] solid_frame[9];
      logic [7:0] mixed_frame[9];
      int         shade_mix[4];
      int         roll, mode;
      logic [7:0] thr;
      bit         need_config;

      solid_frame = '{8'd0, 8'd127, 8'd0, 8'd127, 8'd0, 8'd0, 8'd0, 8'd0, 8'd127};
      mixed_frame = '{8'd255, 8'd0, 8'd128, 8'd1, 8'd0, 8'd255, 8'd0, 8'd1, 8'd0};
      shade_mix   = '{20, 60, 90, 100};
      need_config = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Smallest frames: an all-black one whose centre is interior, then a mixed one
      for (int f = 0; f < 2; f++) begin
         configure((f == 0) ? THRESHOLD_RESET : 8'd0, 9'd3, 9'd3);
         for (int i = 0; i < 9; i++) begin
            if (i == 4) send_item(OP_DRAIN, 8'hFF);
            send_item(OP_PIXEL, (f == 0) ? solid_frame[i] : mixed_frame[i]);
         end
         for (int j = 0; j < 4; j++)
            send_item((j % 2) ? OP_DRAIN : OP_PIXEL, 8'(j * 85));
         counted_items += 13;
         frames_sent++;
      end

      while (counted_items < ITEM_TARGET) begin
         roll = $urandom_range(0, 99);
         mode = (roll < 10) ? MODE_ABANDON : (roll < 20) ? MODE_RETUNE : MODE_WHOLE;
         if (need_config || $urandom_range(0, 99) < 40) begin
            roll = $urandom_range(0, 99);
            thr  = (roll < 15) ? 8'd0 : (roll < 30) ? 8'd255 : (roll < 45) ? 8'd127 :
                   8'($urandom);
            configure(thr,
                      ($urandom_range(0, 99) < 15) ? 9'($urandom_range(0, 2)) :
                                                     9'($urandom_range(3, 10)),
                      ($urandom_range(0, 99) < 15) ? 9'($urandom_range(0, 2)) :
                                                     9'($urandom_range(3, 8)));
         end
         // an abandoned frame is restarted by the next geometry write
         need_config = (mode == MODE_ABANDON);
         run_frame(shade_mix[$urandom_range(0, 3)], mode);
      end

      // Widest frame with both sides streaming flat out
      calm = 1'b1;
      configure(8'($urandom), 9'h1FF, 9'd3);
      run_frame(60, MODE_WHOLE);
      calm = 1'b0;

      wait_idle();
      $display("Ran %0d frames from 3x3 up to 256 wide, %0d counted items.",
               frames_sent, counted_items);
      $display("Checked %0d result pixels, %0d interior pixels cleared to white.",
               result_count, interior_count);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
